// ----- sv/dfmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dfmc_pkg
// Shared types and constants for the table-driven DFA matcher with captures.
// ----------------------------------------------------------------------------
package dfmc_pkg;

	localparam int MAX_STATES    = 256;
	localparam int MAX_META      = 256;
	localparam int MAX_GROUPS    = 8;
	localparam int POSITION_BITS = 16;
	localparam int COLUMNS       = 256;

	localparam int CODE_W  = 10;
	localparam int STATE_W = $clog2(MAX_STATES);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int MV_AW   = STATE_W + COL_W;
	localparam int META_AW = $clog2(MAX_META);
	localparam int GRP_W   = 4;
	localparam int POS_W   = POSITION_BITS;

	localparam logic [CODE_W-1:0] NO_MOVE  = 10'd1023;
	localparam logic [GRP_W-1:0]  NO_GROUP = 4'd8;

	typedef enum logic [2:0] {
		CMD_WR_MOVE = 3'd0,
		CMD_WR_META = 3'd1,
		CMD_BEGIN   = 3'd2,
		CMD_DATA    = 3'd3,
		CMD_FINISH  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_RUNNING  = 2'd0,
		ST_ACCEPT   = 2'd1,
		ST_REJECTED = 2'd2,
		ST_ENDED    = 2'd3
	} status_t;

	typedef struct packed {
		logic [CODE_W-1:0] next;
		logic [GRP_W-1:0]  open_g;
		logic [GRP_W-1:0]  close_g;
	} meta_t;

	typedef struct packed {
		logic               mv_we;
		logic [MV_AW-1:0]   mv_waddr;
		logic [CODE_W-1:0]  mv_wdata;
		logic [MV_AW-1:0]   mv_raddr;
		logic               meta_we;
		logic [META_AW-1:0] meta_waddr;
		meta_t              meta_wdata;
		logic [META_AW-1:0] meta_raddr;
	} tbl_req_t;

endpackage

// ----- sv/dfmc_tables.sv -----
// ----------------------------------------------------------------------------
// dfmc_tables
// Move table and meta table memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module dfmc_tables (
	input  logic                          clk,
	input  dfmc_pkg::tbl_req_t            req,
	output logic [dfmc_pkg::CODE_W-1:0]   mv_rdata,
	output dfmc_pkg::meta_t               meta_rdata
);
	import dfmc_pkg::*;

	logic [CODE_W-1:0] mv_mem [COLUMNS*MAX_STATES];
	meta_t             meta_mem [MAX_META];

	always_ff @(posedge clk) begin
		if (req.mv_we) begin
			mv_mem[req.mv_waddr] <= req.mv_wdata;
		end
		mv_rdata <= mv_mem[req.mv_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.meta_we) begin
			meta_mem[req.meta_waddr] <= req.meta_wdata;
		end
		meta_rdata <= meta_mem[req.meta_raddr];
	end

endmodule

// ----- sv/table_dfa_matcher_with_captures.sv -----
// ----------------------------------------------------------------------------
// table_dfa_matcher_with_captures
// Byte-stream DFA matcher with capture groups driven by a small sequencer.
// ----------------------------------------------------------------------------
// Table writes, begin and unknown words are taken in S_IDLE and leave the block ready.
// A data word's result comes from S_ACC if the byte is ignored, S_MOVE if the move
// rejects, S_WALK if the chain rejects, and S_ACC again after S_WALK and S_AREQ if
// consumed, plus S_META per meta entry; one move read port and the meta walk set this.
// A finish word gives status from S_ACC, then one group word per cycle with m_tready.
// arst_n clears run state, config and result registers; tables stay undefined.
module table_dfa_matcher_with_captures (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cmd[2:0] table_index[10:3] byte_value[18:11]
	                               // next_state[28:19] open_group[32:29] close_group[36:33]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[1:0] group_index[5:2] group_start[21:6]
	                               // group_end[37:22] last_closed[41:38]
	output logic        m_tlast    // last_item
);
	import dfmc_pkg::*;

	localparam logic [1:0] REG_NUM_STATES = 2'd0;
	localparam logic [1:0] REG_SEARCH     = 2'd1;
	localparam logic [1:0] REG_MATCH      = 2'd2;
	localparam logic [1:0] REG_GROUPS     = 2'd3;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_AREQ = 7'b0000010,
		S_ACC  = 7'b0000100,
		S_MOVE = 7'b0001000,
		S_WALK = 7'b0010000,
		S_META = 7'b0100000,
		S_OUT  = 7'b1000000
	} fsm_t;

	// configuration
	logic [8:0]  num_states_q;
	logic        search_q;
	logic [7:0]  match_q;
	logic [3:0]  group_count_q;

	// run state
	fsm_t              state_q;
	logic [CODE_W-1:0] cur_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  starts_q [MAX_GROUPS];
	logic [POS_W-1:0]  ends_q [MAX_GROUPS];
	logic [GRP_W-1:0]  last_group_q;
	logic              rej_q;
	logic              done_q;

	// per-word working registers
	logic              is_fin_q;
	logic              post_q;
	logic [7:0]        bv_q;
	logic [CODE_W-1:0] code_q;
	logic [8:0]        visits_q;
	logic              rng_q;
	logic [3:0]        gidx_q;

	// result register
	logic              ov_q;
	logic [1:0]        o_st_q;
	logic [3:0]        o_gi_q;
	logic [POS_W-1:0]  o_gs_q;
	logic [POS_W-1:0]  o_ge_q;
	logic [3:0]        o_lc_q;
	logic              o_last_q;

	tbl_req_t          req;
	logic [CODE_W-1:0] mv_rdata;
	meta_t             meta_rdata;

	// input word fields
	logic [2:0]        in_cmd;
	logic [7:0]        in_ti;
	logic [7:0]        in_bv;
	logic [CODE_W-1:0] in_ns;
	logic [3:0]        in_og;
	logic [3:0]        in_cg;

	assign in_cmd = s_tdata[2:0];
	assign in_ti  = s_tdata[10:3];
	assign in_bv  = s_tdata[18:11];
	assign in_ns  = s_tdata[28:19];
	assign in_og  = s_tdata[32:29];
	assign in_cg  = s_tdata[36:33];

	logic              s_acc;
	logic              in_rng;
	logic              acc_now;
	logic [CODE_W-1:0] move_code;
	logic [POS_W-1:0]  end_pos;
	logic              is_real;
	logic [CODE_W-1:0] meta_idx;
	logic [3:0]        n_rep;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// current state must be a real, in-table state for any lookup
	assign in_rng   = (cur_q < {1'b0, num_states_q}) && (cur_q < CODE_W'(MAX_STATES));
	assign acc_now  = rng_q && (mv_rdata != NO_MOVE);
	assign move_code = rng_q ? mv_rdata : NO_MOVE;
	assign end_pos  = (pos_q == {POS_W{1'b1}}) ? pos_q : pos_q + POS_W'(1);

	// shared compare/subtract unit for the meta walk
	assign is_real  = code_q < {1'b0, num_states_q};
	assign meta_idx = code_q - {1'b0, num_states_q};

	assign n_rep = (group_count_q > 4'(MAX_GROUPS)) ? 4'(MAX_GROUPS) : group_count_q;

	always_comb begin
		req            = '0;
		req.mv_we      = s_acc && (in_cmd == CMD_WR_MOVE);
		req.mv_waddr   = {in_ti[STATE_W-1:0], in_bv};
		req.mv_wdata   = in_ns;
		// consume read in S_ACC, acceptance read otherwise
		req.mv_raddr   = (state_q == S_ACC) ? {cur_q[STATE_W-1:0], bv_q}
		                                    : {cur_q[STATE_W-1:0], match_q};
		req.meta_we    = s_acc && (in_cmd == CMD_WR_META);
		req.meta_waddr = in_ti[META_AW-1:0];
		req.meta_wdata = '{next: in_ns, open_g: in_og, close_g: in_cg};
		req.meta_raddr = meta_idx[META_AW-1:0];
	end

	dfmc_tables u_tables (
		.clk        (clk),
		.req        (req),
		.mv_rdata   (mv_rdata),
		.meta_rdata (meta_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= 9'd1;
			search_q      <= 1'b0;
			match_q       <= 8'd0;
			group_count_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_STATES: num_states_q  <= cfg_data;
				REG_SEARCH:     search_q      <= cfg_data[0];
				REG_MATCH:      match_q       <= cfg_data[7:0];
				REG_GROUPS:     group_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// range flag is registered so that it lines up with the move read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= 1'b0;
		end else begin
			rng_q <= in_rng;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			pos_q        <= '0;
			last_group_q <= NO_GROUP;
			rej_q        <= 1'b0;
			done_q       <= 1'b0;
			is_fin_q     <= 1'b0;
			post_q       <= 1'b0;
			bv_q         <= '0;
			code_q       <= '0;
			ov_q         <= 1'b0;
			o_st_q       <= '0;
			o_gi_q       <= '0;
			o_gs_q       <= '0;
			o_ge_q       <= '0;
			o_lc_q       <= '0;
			o_last_q     <= 1'b0;
			gidx_q       <= '0;
			visits_q     <= '0;
			for (int i = 0; i < MAX_GROUPS; i++) begin
				starts_q[i] <= '0;
				ends_q[i]   <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						bv_q     <= in_bv;
						is_fin_q <= (in_cmd == CMD_FINISH);
						post_q   <= 1'b0;
						gidx_q   <= '0;
						if (in_cmd == CMD_BEGIN) begin
							cur_q        <= '0;
							pos_q        <= '0;
							last_group_q <= NO_GROUP;
							rej_q        <= 1'b0;
							done_q       <= 1'b0;
							for (int i = 0; i < MAX_GROUPS; i++) begin
								starts_q[i] <= '0;
								ends_q[i]   <= '0;
							end
						end
						// acceptance read of cur_q issued this cycle
						if (in_cmd == CMD_DATA || in_cmd == CMD_FINISH) begin
							state_q <= S_ACC;
						end
					end
				end
				S_AREQ: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					o_gi_q   <= NO_GROUP;
					o_gs_q   <= '0;
					o_ge_q   <= '0;
					o_lc_q   <= last_group_q;
					o_last_q <= 1'b0;
					if (is_fin_q) begin
						o_st_q   <= rej_q ? ST_REJECTED : (acc_now ? ST_ACCEPT : ST_ENDED);
						o_last_q <= (n_rep == 4'd0);
						ov_q     <= 1'b1;
						state_q  <= S_OUT;
					end else if (post_q) begin
						o_st_q  <= acc_now ? ST_ACCEPT : ST_RUNNING;
						ov_q    <= 1'b1;
						state_q <= S_OUT;
					end else if (rej_q) begin
						o_st_q  <= ST_REJECTED;
						ov_q    <= 1'b1;
						state_q <= S_OUT;
					end else if (done_q || (search_q && acc_now)) begin
						// hold the byte unconsumed once accepting
						done_q  <= 1'b1;
						o_st_q  <= ST_ACCEPT;
						ov_q    <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					visits_q <= '0;
					code_q   <= move_code;
					if (move_code == NO_MOVE) begin
						rej_q   <= 1'b1;
						o_st_q  <= ST_REJECTED;
						o_lc_q  <= last_group_q;
						ov_q    <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (is_real) begin
						cur_q   <= code_q;
						pos_q   <= end_pos;
						post_q  <= 1'b1;
						state_q <= S_AREQ;
					end else if (code_q == NO_MOVE || visits_q[8] ||
					             meta_idx[CODE_W-1:META_AW] != '0) begin
						rej_q   <= 1'b1;
						o_st_q  <= ST_REJECTED;
						o_lc_q  <= last_group_q;
						ov_q    <= 1'b1;
						state_q <= S_OUT;
					end else begin
						visits_q <= visits_q + 9'd1;
						state_q  <= S_META;
					end
				end
				S_META: begin
					if (meta_rdata.open_g < 4'(MAX_GROUPS)) begin
						starts_q[meta_rdata.open_g[2:0]] <= pos_q;
					end
					if (meta_rdata.close_g < 4'(MAX_GROUPS)) begin
						ends_q[meta_rdata.close_g[2:0]] <= end_pos;
						last_group_q <= meta_rdata.close_g;
					end
					code_q  <= meta_rdata.next;
					state_q <= S_WALK;
				end
				S_OUT: begin
					if (m_tready) begin
						if (is_fin_q && gidx_q != n_rep) begin
							// advance to the next group word
							o_gi_q   <= gidx_q;
							o_gs_q   <= starts_q[gidx_q[2:0]];
							o_ge_q   <= ends_q[gidx_q[2:0]];
							o_lc_q   <= last_group_q;
							o_last_q <= (gidx_q + 4'd1 == n_rep);
							gidx_q   <= gidx_q + 4'd1;
						end else begin
							ov_q    <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {6'd0, o_lc_q, o_ge_q, o_gs_q, o_gi_q, o_st_q};
	assign m_tlast  = o_last_q;

endmodule

// ----- sv/dfmc_checker.sv -----
// ----------------------------------------------------------------------------
// dfmc_checker
// Port-level checks on the matcher's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module dfmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic        m_tlast,
	input logic [47:0] m_tdata
);

	// never take a word while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// no result shows in the cycle right after an accepted word
	a_no_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result in the cycle after accept");

	// hold a stalled result
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result changed");

	// no result is shown in the cycle right after the last word is taken
	a_group_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result follows last word");

endmodule

bind table_dfa_matcher_with_captures dfmc_checker u_dfmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tlast  (m_tlast),
	.m_tdata  (m_tdata)
);

// ----- test/dfmc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfmc_scoreboard
// Watches the config port and both streams of the DFA matcher, keeps its own
// copy of the tables and run state, and compares every result word in order.
// ----------------------------------------------------------------------------
package dfmc_tb_pkg;

	typedef enum logic [1:0] {
		REG_NUM_STATES  = 2'd0,
		REG_SEARCH_MODE = 2'd1,
		REG_MATCH_CODE  = 2'd2,
		REG_GROUP_COUNT = 2'd3
	} reg_idx_t;

endpackage

module dfmc_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          words_checked
);
	import dfmc_pkg::*;
	import dfmc_tb_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic [3:0]  group_index;
		logic [15:0] group_start;
		logic [15:0] group_end;
		logic [3:0]  last_closed;
		logic        last_item;
	} match_word_t;

	match_word_t expected_words[$];

	logic [CODE_W-1:0] move_mem [0:65535];
	logic [CODE_W-1:0] meta_next_mem [0:255];
	logic [3:0]        meta_open_mem [0:255];
	logic [3:0]        meta_close_mem [0:255];

	logic [CODE_W-1:0] cur_state;
	logic [15:0]       cur_pos;
	logic [15:0]       cap_start [0:7];
	logic [15:0]       cap_end [0:7];
	logic [3:0]        last_grp;
	logic              rejected;
	logic              done;

	logic [8:0]        num_states;
	logic              search_mode;
	logic [7:0]        match_code;
	logic [3:0]        group_count;

	function automatic logic [CODE_W-1:0] move_of(logic [CODE_W-1:0] st, logic [7:0] col);
		if (st >= num_states || st >= CODE_W'(MAX_STATES))
			return NO_MOVE;
		return move_mem[{st[7:0], col}];
	endfunction

	function automatic bit accepts(logic [CODE_W-1:0] st);
		return move_of(st, match_code) != NO_MOVE;
	endfunction

	task automatic clear_run();
		cur_state = '0;
		cur_pos   = '0;
		for (int g = 0; g < 8; g++) begin
			cap_start[g] = '0;
			cap_end[g]   = '0;
		end
		last_grp = NO_GROUP;
		rejected = 1'b0;
		done     = 1'b0;
	endtask

	// Follow one byte through the move table and any meta chain; 0 on reject.
	function automatic bit step_byte(logic [7:0] b);
		logic [CODE_W-1:0] code;
		logic [15:0]       end_pos;
		int                visits;
		int                idx;
		code    = move_of(cur_state, b);
		end_pos = (cur_pos != 16'hFFFF) ? cur_pos + 16'd1 : cur_pos;
		visits  = 0;
		if (code == NO_MOVE)
			return 0;
		while (code >= num_states) begin
			if (code == NO_MOVE || visits >= MAX_META)
				return 0;
			idx = int'(code) - int'(num_states);
			if (idx >= MAX_META)
				return 0;
			visits++;
			if (meta_open_mem[idx] < NO_GROUP)
				cap_start[meta_open_mem[idx][2:0]] = cur_pos;
			if (meta_close_mem[idx] < NO_GROUP) begin
				cap_end[meta_close_mem[idx][2:0]] = end_pos;
				last_grp = meta_close_mem[idx];
			end
			code = meta_next_mem[idx];
		end
		cur_state = code;
		cur_pos   = end_pos;
		return 1;
	endfunction

	function automatic match_word_t make_word(logic [1:0] st, logic [3:0] gi,
			logic [15:0] gs, logic [15:0] ge, logic lst);
		match_word_t w;
		w.status      = st;
		w.group_index = gi;
		w.group_start = gs;
		w.group_end   = ge;
		w.last_closed = last_grp;
		w.last_item   = lst;
		return w;
	endfunction

	task automatic predict(logic [39:0] d);
		logic [2:0]        cmd;
		logic [7:0]        tidx;
		logic [7:0]        bval;
		logic [CODE_W-1:0] nxt;
		logic [1:0]        st;
		int                n;
		cmd  = d[2:0];
		tidx = d[10:3];
		bval = d[18:11];
		nxt  = d[28:19];
		case (cmd)
			CMD_WR_MOVE: begin
				move_mem[{tidx, bval}] = nxt;
			end
			CMD_WR_META: begin
				meta_next_mem[tidx]  = nxt;
				meta_open_mem[tidx]  = d[32:29];
				meta_close_mem[tidx] = d[36:33];
			end
			CMD_BEGIN: begin
				clear_run();
			end
			CMD_DATA: begin
				if (!rejected && !done) begin
					if (search_mode && accepts(cur_state))
						done = 1'b1;
					else if (!step_byte(bval))
						rejected = 1'b1;
				end
				if (rejected)
					st = ST_REJECTED;
				else if (done || accepts(cur_state))
					st = ST_ACCEPT;
				else
					st = ST_RUNNING;
				expected_words.push_back(make_word(st, NO_GROUP, '0, '0, 1'b0));
			end
			CMD_FINISH: begin
				n = (group_count > 4'd8) ? 8 : int'(group_count);
				if (rejected)
					st = ST_REJECTED;
				else if (accepts(cur_state))
					st = ST_ACCEPT;
				else
					st = ST_ENDED;
				expected_words.push_back(make_word(st, NO_GROUP, '0, '0, n == 0));
				for (int g = 0; g < n; g++)
					expected_words.push_back(make_word(st, 4'(g), cap_start[g],
						cap_end[g], g + 1 == n));
			end
			default: ;  // unknown command: drop
		endcase
	endtask

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_word_t w;
		if (!arst_n) begin
			clear_run();
			num_states  = 9'd1;
			search_mode = 1'b0;
			match_code  = 8'd0;
			group_count = 4'd0;
			expected_words.delete();
			fail_count    = 0;
			words_checked = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					$error("result word with nothing expected: %h", m_tdata);
				end else begin
					w = expected_words.pop_front();
					check_field("status", 16'(w.status), 16'(m_tdata[1:0]));
					check_field("group_index", 16'(w.group_index), 16'(m_tdata[5:2]));
					check_field("group_start", w.group_start, m_tdata[21:6]);
					check_field("group_end", w.group_end, m_tdata[37:22]);
					check_field("last_closed", 16'(w.last_closed), 16'(m_tdata[41:38]));
					check_field("last_item", 16'(w.last_item), 16'(m_tlast));
					words_checked++;
				end
			end
			if (s_tvalid && s_tready)
				predict(s_tdata);
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_STATES:  num_states  = cfg_data;
					REG_SEARCH_MODE: search_mode = cfg_data[0];
					REG_MATCH_CODE:  match_code  = cfg_data[7:0];
					REG_GROUP_COUNT: group_count = cfg_data[3:0];
					default: ;
				endcase
			end
		end
		pending = expected_words.size();
	end

endmodule

// ----- test/tb_table_dfa_matcher_with_captures.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_dfa_matcher_with_captures
// Loads small DFAs with meta chains and runs directed and random byte streams
// through several configurations, with and without back-pressure.
// ----------------------------------------------------------------------------
module tb_table_dfa_matcher_with_captures;
	import dfmc_pkg::*;
	import dfmc_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int META_USED      = 8;
	localparam int COL_BASE       = 8'h41;
	localparam int N_COLS         = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // cmd table_index byte_value next_state open_group close_group
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // status group_index group_start group_end last_closed
	logic        m_tlast;

	int fail_count;
	int pending;
	int words_checked;
	int words_sent;
	int idle_cycles;
	bit idle_on;

	// Config shadow used to pick legal codes while building tables.
	int cur_states;
	int cur_match;

	table_dfa_matcher_with_captures dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	dfmc_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending      (pending),
		.words_checked(words_checked)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure: stall about a third of the time when idling is on.
	always @(posedge clk) begin
		m_tready <= idle_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
	end

	// Watchdog: give up after a long stretch with no word moving either way.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_table_dfa_matcher_with_captures NOT OK");
			$finish;
		end
	end

	// Present one word and hold it until accepted; valid stays high for the next.
	task automatic send_word(cmd_t cmd, logic [7:0] tidx, logic [7:0] bval,
			logic [9:0] nxt, logic [3:0] og, logic [3:0] cg);
		if (idle_on && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 35);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, cg, og, nxt, bval, tidx, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
	endtask

	task automatic send_data(logic [7:0] b);
		send_word(CMD_DATA, 8'($urandom), b, 10'($urandom), 4'($urandom), 4'($urandom));
	endtask

	task automatic send_cmd(cmd_t cmd);
		send_word(cmd, 8'($urandom), 8'($urandom), 10'($urandom), 4'($urandom),
			4'($urandom));
	endtask

	// Hold until every expected word is in, then let the block settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(int ns, int sm, int mc, int gc);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_STATES;
		cfg_data  <= 9'(ns);
		@(posedge clk);
		cfg_index <= REG_SEARCH_MODE;
		cfg_data  <= 9'(sm);
		@(posedge clk);
		cfg_index <= REG_MATCH_CODE;
		cfg_data  <= 9'(mc);
		@(posedge clk);
		cfg_index <= REG_GROUP_COUNT;
		cfg_data  <= 9'(gc);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_states = ns;
		cur_match  = mc;
	endtask

	// Real states are kept below four so that only written rows are reached.
	function automatic logic [9:0] real_code();
		return 10'($urandom_range(0, (cur_states < 4 ? cur_states : 4) - 1));
	endfunction

	// Data bytes come from a few columns plus the match column, all written.
	function automatic logic [7:0] pick_col();
		if ($urandom_range(0, 4) == 0)
			return 8'(cur_match);
		return 8'(COL_BASE + $urandom_range(0, N_COLS - 1));
	endfunction

	function automatic logic [9:0] pick_code(int real_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < real_pct)
			return real_code();
		if (r < 88)
			return 10'(cur_states + $urandom_range(0, META_USED - 1));
		if (r < 94)
			return 10'(cur_states + $urandom_range(MAX_META, 1022 - cur_states));
		return NO_MOVE;
	endfunction

	function automatic logic [3:0] pick_group();
		return ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
			: 4'($urandom_range(9, 15));
	endfunction

	// Rewrite every reachable move entry and meta entry for this setting.
	task automatic load_tables();
		int rows;
		rows = cur_states < 4 ? cur_states : 4;
		for (int s = 0; s < rows; s++) begin
			for (int c = 0; c < N_COLS; c++)
				send_word(CMD_WR_MOVE, 8'(s), 8'(COL_BASE + c), pick_code(45),
					4'($urandom), 4'($urandom));
			send_word(CMD_WR_MOVE, 8'(s), 8'(cur_match),
				$urandom_range(0, 1) ? NO_MOVE : pick_code(45), 4'($urandom), 4'($urandom));
		end
		for (int i = 0; i < META_USED; i++)
			send_word(CMD_WR_META, 8'(i), 8'($urandom), pick_code(70), pick_group(),
				pick_group());
	endtask

	// Runs of begin, a few bytes and a finish, with some noise mixed in.
	task automatic random_runs(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) != 0) begin
				send_cmd(CMD_BEGIN);
				sent++;
			end
			len = $urandom_range(1, 10);
			repeat (len) send_data(pick_col());
			sent += len;
			case ($urandom_range(0, 9))
				0: send_word(cmd_t'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
					10'($urandom), 4'($urandom), 4'($urandom));
				1: send_word(CMD_WR_MOVE, 8'(real_code()), pick_col(), pick_code(45),
					4'($urandom), 4'($urandom));
				2: send_word(CMD_WR_META, 8'($urandom_range(0, META_USED - 1)),
					8'($urandom), pick_code(70), pick_group(), pick_group());
				default: ;
			endcase
			send_cmd(CMD_FINISH);
			sent++;
		end
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_NUM_STATES;
		cfg_data   <= '0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		idle_on    = 1'b1;
		words_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: four states, match column at the top, all eight groups reported.
		set_config(4, 0, 255, 8);
		load_tables();
		send_word(CMD_WR_MOVE, 8'd0, 8'd255, NO_MOVE, 4'd0, 4'd0);
		send_word(CMD_WR_MOVE, 8'd1, 8'd255, 10'd0, 4'd0, 4'd0);
		send_word(CMD_WR_MOVE, 8'd0, 8'h00, NO_MOVE, 4'd0, 4'd0);
		send_word(CMD_WR_MOVE, 8'd0, 8'h41, 10'd4, 4'd0, 4'd0);    // open 0, close 0
		send_word(CMD_WR_META, 8'd0, 8'd0, 10'd5, 4'd0, NO_GROUP);
		send_word(CMD_WR_META, 8'd1, 8'd0, 10'd1, NO_GROUP, 4'd0);
		send_word(CMD_WR_MOVE, 8'd1, 8'h42, 10'd6, 4'd0, 4'd0);    // groups out of range
		send_word(CMD_WR_META, 8'd2, 8'd0, 10'd1, 4'd15, 4'd12);
		send_word(CMD_WR_MOVE, 8'd1, 8'h43, 10'd7, 4'd0, 4'd0);    // chain hits no-move
		send_word(CMD_WR_META, 8'd3, 8'd0, NO_MOVE, NO_GROUP, NO_GROUP);
		send_word(CMD_WR_MOVE, 8'd0, 8'h44, 10'd8, 4'd0, 4'd0);    // self loop, long chain
		send_word(CMD_WR_META, 8'd4, 8'd0, 10'd8, 4'd1, 4'd2);
		send_word(CMD_WR_MOVE, 8'd0, 8'h45, 10'd304, 4'd0, 4'd0);  // meta index past table

		send_cmd(CMD_BEGIN);
		send_data(8'h41);
		send_data(8'h42);
		send_cmd(CMD_FINISH);
		send_data(8'h43);
		send_data(8'h41);
		send_cmd(CMD_FINISH);
		send_cmd(CMD_BEGIN);
		send_data(8'h00);
		send_cmd(CMD_BEGIN);
		send_data(8'hFF);
		send_cmd(CMD_FINISH);
		send_cmd(CMD_BEGIN);
		send_data(8'h44);
		send_cmd(CMD_FINISH);
		send_cmd(CMD_BEGIN);
		send_data(8'h45);
		send_cmd(CMD_BEGIN);
		send_cmd(CMD_FINISH);
		send_word(cmd_t'(3'd7), 8'hFF, 8'hFF, 10'h3FF, 4'hF, 4'hF);
		send_word(cmd_t'(3'd5), 8'h00, 8'h00, 10'h000, 4'h0, 4'h0);
		send_word(cmd_t'(3'd6), 8'hA5, 8'h5A, 10'h2AA, 4'h5, 4'hA);
		wait_idle();

		// Random phases over several settings, extremes included.
		set_config(4, 1, 0, 3);
		load_tables();
		random_runs(30);
		wait_idle();

		set_config(256, 0, $urandom_range(0, 255), 0);
		load_tables();
		random_runs(30);
		wait_idle();

		set_config(1, 1, 128, 15);
		load_tables();
		random_runs(30);
		wait_idle();

		set_config(3, 0, 255, 1);
		load_tables();
		random_runs(30);
		wait_idle();

		// Last phase runs with no idling on either side.
		idle_on = 1'b0;
		set_config(2, 1, 7, 8);
		load_tables();
		random_runs(30);
		wait_idle();
		idle_on = 1'b1;

		$display("Sent %0d words over six table settings, checked %0d result words.",
			words_sent, words_checked);
		$display("Covered captures, meta chains, rejects, search stop and back-pressure.");
		if (fail_count == 0)
			$display("tb_table_dfa_matcher_with_captures OK");
		else
			$display("tb_table_dfa_matcher_with_captures NOT OK");
		$finish;
	end

endmodule
